>>> hw/rtl/edge_truncated_moving_average_threshold_defines.svh
// assertion macros for the moving average threshold block
`ifndef EDGE_TRUNCATED_MOVING_AVERAGE_THRESHOLD_DEFINES_SVH
`define EDGE_TRUNCATED_MOVING_AVERAGE_THRESHOLD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ETMAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ETMAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define ETMAT_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/etmat_pkg.sv
// shared types and constants of the moving average threshold block
package etmat_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int INDEX_W        = 17;
    localparam int APB_ADDR_W     = 3;
    localparam int DIV_RADIX_BITS = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [INDEX_W-1:0]  t_index;

    // register index codes
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    // reported index when the average misses the threshold
    localparam t_index NO_HIT = '1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

>>> hw/rtl/etmat_queue.sv
// two-entry job queue between the front and back parts
module etmat_queue #(
    parameter int DATA_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [DATA_W-1:0]         i_push_data,
    input  logic                      i_pop,
    output logic [DATA_W-1:0]         o_pop_data,
    output etmat_pkg::t_q_flags       o_flags
);
    import etmat_pkg::*;

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][DATA_W-1:0] r_mem;
    logic [PTR_W-1:0]             r_wr, n_wr;
    logic [PTR_W-1:0]             r_rd, n_rd;
    logic [FILL_W-1:0]            r_fill, n_fill;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data    = r_mem[r_rd];
    assign o_flags.full  = (r_fill == FILL_W'(DEPTH));
    assign o_flags.empty = (r_fill == '0);

endmodule

>>> hw/rtl/etmat_front.sv
// front part: takes samples, keeps the history and queues averaging jobs
module etmat_front #(
    parameter int WINDOW_RADIUS     = 2,
    parameter int MAX_STREAM_LENGTH = 65536,
    localparam int HIST_LEN = 2 * WINDOW_RADIUS,
    localparam int CAP      = MAX_STREAM_LENGTH + HIST_LEN,
    localparam int CNT_W    = $clog2(CAP + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  etmat_pkg::t_sample                        i_sample,
    input  logic                                      i_last_in,
    input  etmat_pkg::t_q_flags                       i_q_flags,
    output logic                                      o_push,
    output logic [HIST_LEN:0][etmat_pkg::SAMPLE_W-1:0] o_job_win,
    output logic [CNT_W-1:0]                          o_job_cur,
    output logic                                      o_job_last
);
    import etmat_pkg::*;

    logic [HIST_LEN-1:0][SAMPLE_W-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic                              accept;

    assign o_in_stall = i_q_flags.full;
    assign accept     = i_in_valid && !i_q_flags.full;

    // a job only when this word produces at least one result
    assign o_push     = accept && (i_last_in || (r_count >= CNT_W'(WINDOW_RADIUS)));
    assign o_job_cur  = r_count;
    assign o_job_last = i_last_in;

    // window oldest first, newest sample on top
    always_comb begin
        for (int k = 0; k < HIST_LEN; k++) begin
            o_job_win[k] = r_hist[HIST_LEN-1-k];
        end
        o_job_win[HIST_LEN] = i_sample;
    end

    always_comb begin
        n_hist  = r_hist;
        n_count = r_count;
        if (accept) begin
            if (i_last_in) begin
                n_hist  = '0;
                n_count = '0;
            end else begin
                for (int k = HIST_LEN - 1; k > 0; k--) begin
                    n_hist[k] = r_hist[k-1];
                end
                n_hist[0] = i_sample;
                if (r_count < CNT_W'(CAP)) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_count <= '0;
        end else begin
            r_hist  <= n_hist;
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/etmat_back.sv
// back part: sums each window, divides by the neighbour count and drives results
module etmat_back #(
    parameter int WINDOW_RADIUS     = 2,
    parameter int MAX_STREAM_LENGTH = 65536,
    localparam int HIST_LEN = 2 * WINDOW_RADIUS,
    localparam int CAP      = MAX_STREAM_LENGTH + HIST_LEN,
    localparam int CNT_W    = $clog2(CAP + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  etmat_pkg::t_q_flags                       i_q_flags,
    output logic                                      o_pop,
    input  logic [HIST_LEN:0][etmat_pkg::SAMPLE_W-1:0] i_job_win,
    input  logic [CNT_W-1:0]                          i_job_cur,
    input  logic                                      i_job_last,
    input  etmat_pkg::t_sample                        i_threshold,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output etmat_pkg::t_sample                        o_average,
    output etmat_pkg::t_index                         o_hit_index,
    output logic                                      o_last_out
);
    import etmat_pkg::*;

    localparam int WIN_LEN   = HIST_LEN + 1;
    localparam int K_W       = $clog2(WIN_LEN);
    localparam int E_W       = $clog2(WINDOW_RADIUS + 1);
    localparam int NCNT_W    = $clog2(WIN_LEN + 1);
    localparam int REM_W     = NCNT_W;
    localparam int SUM_W     = SAMPLE_W + $clog2(WIN_LEN);
    localparam int STEPS     = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int PAD_W     = STEPS * DIV_RADIX_BITS;
    localparam int STEP_W    = $clog2(STEPS);
    localparam int IDXV_W    = INDEX_W - 1;
    localparam int IDX_LIMIT = (MAX_STREAM_LENGTH - 1 < 65535) ? MAX_STREAM_LENGTH - 1 : 65535;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SETUP   = 3'd1;
    localparam logic [2:0] S_ACC     = 3'd2;
    localparam logic [2:0] S_DIVINIT = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_NEG     = 3'd5;
    localparam logic [2:0] S_RES     = 3'd6;

    logic [2:0]                       r_state, n_state;
    logic [HIST_LEN:0][SAMPLE_W-1:0]  r_win, n_win;
    logic [CNT_W-1:0]                 r_cur, n_cur;
    logic                             r_last, n_last;
    logic [E_W-1:0]                   r_e, n_e;
    logic [K_W-1:0]                   r_k, n_k;
    logic signed [SUM_W-1:0]          r_sum, n_sum;
    logic [NCNT_W-1:0]                r_cnt, n_cnt;
    logic                             r_neg, n_neg;
    logic [PAD_W-1:0]                 r_quo, n_quo;
    logic [REM_W-1:0]                 r_rem, n_rem;
    logic [STEP_W-1:0]                r_step, n_step;
    logic [SAMPLE_W-1:0]              r_avg, n_avg;
    logic [IDXV_W-1:0]                r_idx, n_idx;
    logic                             r_o_valid, n_o_valid;
    t_sample                          r_o_avg, n_o_avg;
    t_index                           r_o_hit, n_o_hit;
    logic                             r_o_last, n_o_last;

    logic [K_W-1:0]                   lo_radius, lo_stream, k_lo;
    logic [SUM_W-1:0]                 mag;
    logic [PAD_W-1:0]                 quo_s;
    logic [CNT_W-1:0]                 pos;
    logic [REM_W-1:0]                 div_rem [DIV_RADIX_BITS+1];
    logic [PAD_W-1:0]                 div_quo [DIV_RADIX_BITS+1];
    logic [REM_W:0]                   div_sh  [DIV_RADIX_BITS];

    // first window slot: clipped by the radius and by the start of the stream
    assign lo_radius = K_W'(WINDOW_RADIUS) - K_W'(r_e);
    assign lo_stream = (r_cur >= CNT_W'(HIST_LEN)) ? '0 : K_W'(HIST_LEN) - K_W'(r_cur);
    assign k_lo      = (lo_radius > lo_stream) ? lo_radius : lo_stream;

    assign mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign quo_s = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign pos   = r_cur - CNT_W'(r_e);

    // restoring division, DIV_RADIX_BITS quotient bits per cycle
    always_comb begin
        div_rem[0] = r_rem;
        div_quo[0] = r_quo;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            div_sh[i]    = {div_rem[i], div_quo[i][PAD_W-1]};
            div_quo[i+1] = {div_quo[i][PAD_W-2:0], 1'b0};
            if (div_sh[i] >= (REM_W+1)'(r_cnt)) begin
                div_rem[i+1]    = REM_W'(div_sh[i] - (REM_W+1)'(r_cnt));
                div_quo[i+1][0] = 1'b1;
            end else begin
                div_rem[i+1] = div_sh[i][REM_W-1:0];
            end
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_flags.empty;

    always_comb begin
        n_state   = r_state;
        n_win     = r_win;
        n_cur     = r_cur;
        n_last    = r_last;
        n_e       = r_e;
        n_k       = r_k;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_step    = r_step;
        n_avg     = r_avg;
        n_idx     = r_idx;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_avg   = r_o_avg;
        n_o_hit   = r_o_hit;
        n_o_last  = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_flags.empty) begin
                    n_win  = i_job_win;
                    n_cur  = i_job_cur;
                    n_last = i_job_last;
                    n_e    = (i_job_cur >= CNT_W'(WINDOW_RADIUS)) ?
                             E_W'(WINDOW_RADIUS) : E_W'(i_job_cur);
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_k     = k_lo;
                n_sum   = '0;
                n_cnt   = '0;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum = r_sum + $signed({{(SUM_W-SAMPLE_W){r_win[r_k][SAMPLE_W-1]}},
                                         r_win[r_k]});
                n_cnt = r_cnt + 1'b1;
                n_k   = r_k + 1'b1;
                if (r_k == K_W'(HIST_LEN)) begin
                    n_state = S_DIVINIT;
                end
            end
            S_DIVINIT: begin
                n_neg   = r_sum[SUM_W-1];
                n_quo   = PAD_W'(mag);
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = div_rem[DIV_RADIX_BITS];
                n_quo  = div_quo[DIV_RADIX_BITS];
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                n_avg   = quo_s[SAMPLE_W-1:0];
                n_idx   = (pos < CNT_W'(IDX_LIMIT)) ? IDXV_W'(pos) : IDXV_W'(IDX_LIMIT);
                n_state = S_RES;
            end
            S_RES: begin
                if (!n_o_valid) begin
                    n_o_valid = 1'b1;
                    n_o_avg   = r_avg;
                    n_o_hit   = ($signed(r_avg) >= i_threshold) ? {1'b0, r_idx} : NO_HIT;
                    n_o_last  = r_last && (r_e == '0);
                    if (!r_last || (r_e == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e - 1'b1;
                        n_state = S_SETUP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_cur    <= n_cur;
        r_last   <= n_last;
        r_e      <= n_e;
        r_k      <= n_k;
        r_sum    <= n_sum;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_avg    <= n_avg;
        r_idx    <= n_idx;
        r_o_avg  <= n_o_avg;
        r_o_hit  <= n_o_hit;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_average   = r_o_avg;
    assign o_hit_index = r_o_hit;
    assign o_last_out  = r_o_last;

endmodule

>>> hw/rtl/edge_truncated_moving_average_threshold.sv
// a result costs a pop, a setup step, accumulation of up to 2*WINDOW_RADIUS+1 samples,
// a divider load, the divider steps of DIV_RADIX_BITS quotient bits each and two
// finishing steps, sign fix then result; flush results skip the pop
// throughput: one word per result time, set by the single back part; output stall holds it
// reset: synchronous active low, clears history, position count, queue, threshold, out valid
module edge_truncated_moving_average_threshold #(
    parameter int WINDOW_RADIUS     = 2,
    parameter int MAX_STREAM_LENGTH = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  etmat_pkg::t_sample                    i_sample,
    input  logic                                  i_last_in,
    // result words
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output etmat_pkg::t_sample                    o_average,
    output etmat_pkg::t_index                     o_hit_index,
    output logic                                  o_last_out,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [etmat_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import etmat_pkg::*;

    localparam int HIST_LEN = 2 * WINDOW_RADIUS;
    localparam int CNT_W    = $clog2(MAX_STREAM_LENGTH + HIST_LEN + 1);
    localparam int JOB_W    = 1 + CNT_W + (HIST_LEN + 1) * SAMPLE_W;

    // threshold register, the only one
    t_sample r_threshold;
    logic    reg_hit;
    logic    reg_wr;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD);
    assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? r_threshold : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (reg_wr) begin
            r_threshold <= pwdata;
        end
    end

    // front to queue: one job per word that yields results
    logic                              f_push;
    logic [HIST_LEN:0][SAMPLE_W-1:0]   f_win;
    logic [CNT_W-1:0]                  f_cur;
    logic                              f_last;
    logic [JOB_W-1:0]                  q_push_data;
    logic [JOB_W-1:0]                  q_pop_data;
    logic                              b_pop;
    t_q_flags                          q_flags;

    // queue to back
    logic [HIST_LEN:0][SAMPLE_W-1:0]   b_win;
    logic [CNT_W-1:0]                  b_cur;
    logic                              b_last;

    etmat_front #(
        .WINDOW_RADIUS     (WINDOW_RADIUS),
        .MAX_STREAM_LENGTH (MAX_STREAM_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_last_in  (i_last_in),
        .i_q_flags  (q_flags),
        .o_push     (f_push),
        .o_job_win  (f_win),
        .o_job_cur  (f_cur),
        .o_job_last (f_last)
    );

    assign q_push_data = {f_last, f_cur, f_win};

    etmat_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_push_data (q_push_data),
        .i_pop       (b_pop),
        .o_pop_data  (q_pop_data),
        .o_flags     (q_flags)
    );

    assign {b_last, b_cur, b_win} = q_pop_data;

    etmat_back #(
        .WINDOW_RADIUS     (WINDOW_RADIUS),
        .MAX_STREAM_LENGTH (MAX_STREAM_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_flags   (q_flags),
        .o_pop       (b_pop),
        .i_job_win   (b_win),
        .i_job_cur   (b_cur),
        .i_job_last  (b_last),
        .i_threshold (r_threshold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_average   (o_average),
        .o_hit_index (o_hit_index),
        .o_last_out  (o_last_out)
    );

endmodule

>>> hw/rtl/etmat_checker.sv
// port-level checks on the moving average threshold block, bound to the top level
`include "edge_truncated_moving_average_threshold_defines.svh"

module etmat_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  etmat_pkg::t_index                 o_hit_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [etmat_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    input  logic [31:0]                       prdata
);
    import etmat_pkg::*;

    // a stalled result word stays offered
    `ETMAT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result word dropped under stall")

    // index is either a position or the miss code
    `ETMAT_ASSERT_NOW(a_hit_form, o_out_valid, !o_hit_index[INDEX_W-1] || o_hit_index == NO_HIT, "bad hit index")

    // reset empties the queue and the output register
    `ETMAT_ASSERT_RESET(a_reset_clear, !i_rst_n, !o_out_valid && !o_in_stall, "reset did not clear")

    // threshold reads back what was written
    `ETMAT_ASSERT_NOW(a_cfg_readback, (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_THRESHOLD) ##1 (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD), prdata == $past(pwdata), "threshold readback mismatch")

endmodule

bind edge_truncated_moving_average_threshold etmat_checker u_etmat_checker (.*);
